// ----- src/somr_pkg.sv -----
// Shared types and constants for the spiral-order matrix reader.
package somr_pkg;

    localparam int CFG_W = 5;
    localparam int ROWS_CFG_W = 5;
    localparam int COLS_CFG_W = 3;
    localparam int VALUE_W = 32;
    localparam int OUT_ROW_W = 4;
    localparam int OUT_COL_W = 2;

    localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = 5'd4;
    localparam logic [COLS_CFG_W-1:0] COLS_RESET = 3'd4;

    typedef enum logic [0:0] {
        REG_ROWS = 1'b0,
        REG_COLS = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_LOAD = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    typedef enum logic [3:0] {
        DIR_RIGHT = 4'b0001,
        DIR_DOWN  = 4'b0010,
        DIR_LEFT  = 4'b0100,
        DIR_UP    = 4'b1000
    } dir_t;

    typedef struct packed {
        logic store;
        logic start;
        logic emit;
        logic out_take;
    } somr_cmd_t;

    typedef struct packed {
        logic fill_done;
        logic walk_last;
        logic out_valid;
    } somr_sts_t;

endpackage

// ----- src/somr_dp.sv -----
// Datapath: configuration, element store, spiral walker and output register.
module somr_dp
    import somr_pkg::*;
#(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 4
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  cfg_reg_t                   cfg_index,
    input  logic [CFG_W-1:0]           cfg_wdata,
    input  logic signed [VALUE_W-1:0]  element_value,
    input  somr_cmd_t                  cmd,
    output somr_sts_t                  sts,
    output logic signed [VALUE_W-1:0]  out_value,
    output logic [OUT_ROW_W-1:0]       out_row,
    output logic [OUT_COL_W-1:0]       out_col,
    output logic                       is_last
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TW = $clog2(DEPTH + 1);
    localparam int RCW = $clog2(MAX_ROWS + 1);
    localparam int CCW = $clog2(MAX_COLS + 1);
    localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    logic [ROWS_CFG_W-1:0] rows_reg;
    logic [COLS_CFG_W-1:0] cols_reg;
    logic [RCW-1:0]        eff_rows;
    logic [CCW-1:0]        eff_cols;
    logic [TW-1:0]         total;

    logic [TW-1:0]  load_count_reg, load_count_next;
    logic [TW-1:0]  emit_cnt_reg, emit_cnt_next;
    logic [RIW-1:0] r_reg, r_next, top_reg, top_next, bottom_reg, bottom_next;
    logic [CIW-1:0] c_reg, c_next, left_reg, left_next, right_reg, right_next;
    dir_t           dir_reg, dir_next;
    logic           out_valid_reg, out_valid_next;

    logic [VALUE_W-1:0]   mem [DEPTH];
    logic signed [VALUE_W-1:0] rd_reg;
    logic [OUT_ROW_W-1:0] out_row_reg;
    logic [OUT_COL_W-1:0] out_col_reg;
    logic                 is_last_reg;

    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic          fill_done;
    logic          walk_last;

    always_comb
    begin
        if (rows_reg == '0)
        begin
            eff_rows = RCW'(1);
        end
        else if (int'(rows_reg) > MAX_ROWS)
        begin
            eff_rows = RCW'(MAX_ROWS);
        end
        else
        begin
            eff_rows = RCW'(rows_reg);
        end
        if (cols_reg == '0)
        begin
            eff_cols = CCW'(1);
        end
        else if (int'(cols_reg) > MAX_COLS)
        begin
            eff_cols = CCW'(MAX_COLS);
        end
        else
        begin
            eff_cols = CCW'(cols_reg);
        end
    end

    assign total     = TW'(eff_rows) * TW'(eff_cols);
    assign fill_done = ((TW+1)'(load_count_reg) + (TW+1)'(1)) >= (TW+1)'(total);
    assign walk_last = (emit_cnt_reg == (total - TW'(1)));
    assign wr_addr   = AW'(load_count_reg);
    assign rd_addr   = AW'(TW'(r_reg) * TW'(eff_cols) + TW'(c_reg));

    always_comb
    begin
        load_count_next = load_count_reg;
        emit_cnt_next   = emit_cnt_reg;
        r_next          = r_reg;
        c_next          = c_reg;
        top_next        = top_reg;
        bottom_next     = bottom_reg;
        left_next       = left_reg;
        right_next      = right_reg;
        dir_next        = dir_reg;
        out_valid_next  = out_valid_reg;

        if (cmd.store)
        begin
            load_count_next = fill_done ? '0 : load_count_reg + TW'(1);
        end

        if (cmd.start)
        begin
            emit_cnt_next = '0;
            r_next        = '0;
            c_next        = '0;
            top_next      = '0;
            bottom_next   = RIW'(eff_rows - RCW'(1));
            left_next     = '0;
            right_next    = CIW'(eff_cols - CCW'(1));
            dir_next      = DIR_RIGHT;
        end
        else if (cmd.emit)
        begin
            emit_cnt_next = emit_cnt_reg + TW'(1);
            case (dir_reg)
                DIR_RIGHT:
                begin
                    if (c_reg != right_reg)
                    begin
                        c_next = c_reg + CIW'(1);
                    end
                    else
                    begin
                        top_next = top_reg + RIW'(1);
                        r_next   = r_reg + RIW'(1);
                        dir_next = DIR_DOWN;
                    end
                end
                DIR_DOWN:
                begin
                    if (r_reg != bottom_reg)
                    begin
                        r_next = r_reg + RIW'(1);
                    end
                    else
                    begin
                        right_next = right_reg - CIW'(1);
                        c_next     = c_reg - CIW'(1);
                        dir_next   = DIR_LEFT;
                    end
                end
                DIR_LEFT:
                begin
                    if (c_reg != left_reg)
                    begin
                        c_next = c_reg - CIW'(1);
                    end
                    else
                    begin
                        bottom_next = bottom_reg - RIW'(1);
                        r_next      = r_reg - RIW'(1);
                        dir_next    = DIR_UP;
                    end
                end
                DIR_UP:
                begin
                    if (r_reg != top_reg)
                    begin
                        r_next = r_reg - RIW'(1);
                    end
                    else
                    begin
                        left_next = left_reg + CIW'(1);
                        c_next    = c_reg + CIW'(1);
                        dir_next  = DIR_RIGHT;
                    end
                end
                default:
                begin
                    dir_next = DIR_RIGHT;
                end
            endcase
        end

        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (cmd.out_take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg       <= ROWS_RESET;
            cols_reg       <= COLS_RESET;
            load_count_reg <= '0;
            emit_cnt_reg   <= '0;
            r_reg          <= '0;
            c_reg          <= '0;
            top_reg        <= '0;
            bottom_reg     <= '0;
            left_reg       <= '0;
            right_reg      <= '0;
            dir_reg        <= DIR_RIGHT;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ROWS: rows_reg <= cfg_wdata;
                    REG_COLS: cols_reg <= cfg_wdata[COLS_CFG_W-1:0];
                    default:  rows_reg <= rows_reg;
                endcase
            end
            load_count_reg <= load_count_next;
            emit_cnt_reg   <= emit_cnt_next;
            r_reg          <= r_next;
            c_reg          <= c_next;
            top_reg        <= top_next;
            bottom_reg     <= bottom_next;
            left_reg       <= left_next;
            right_reg      <= right_next;
            dir_reg        <= dir_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            mem[wr_addr] <= element_value;
        end
        if (cmd.emit)
        begin
            rd_reg      <= mem[rd_addr];
            out_row_reg <= OUT_ROW_W'(r_reg);
            out_col_reg <= OUT_COL_W'(c_reg);
            is_last_reg <= walk_last;
        end
    end

    assign sts.fill_done = fill_done;
    assign sts.walk_last = walk_last;
    assign sts.out_valid = out_valid_reg;

    assign out_value = rd_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign is_last   = is_last_reg;

    a_count_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        load_count_reg < TW'(DEPTH))
        else $error("load count beyond store depth");

    a_start_init: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> (emit_cnt_reg == '0) && (dir_reg == DIR_RIGHT))
        else $error("walker not reset at spiral start");

    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid_reg)
        else $error("emitted item not presented");

endmodule

// ----- src/somr_ctrl.sv -----
// Controller: load/emit state machine and handshake commands.
module somr_ctrl
    import somr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      out_stall,
    input  somr_sts_t sts,
    output logic      in_stall,
    output somr_cmd_t cmd
);

    state_t state_reg, state_next;
    logic   accept;

    always_comb
    begin
        in_stall     = (state_reg != ST_LOAD);
        accept       = in_valid && (state_reg == ST_LOAD);
        cmd.store    = accept;
        cmd.start    = accept && sts.fill_done;
        cmd.emit     = (state_reg == ST_EMIT) && (!sts.out_valid || !out_stall);
        cmd.out_take = !out_stall;

        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (cmd.start)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (cmd.emit && sts.walk_last)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_start_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> (state_reg == ST_EMIT))
        else $error("matrix complete but no emission");

    a_last_to_load: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && sts.walk_last) |=> (state_reg == ST_LOAD))
        else $error("emission runs past last element");

    a_no_store_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> !cmd.store)
        else $error("store written during emission");

endmodule

// ----- src/spiral_order_matrix_reader.sv -----
// Top level of the spiral-order matrix reader.
//   channel   direction  handshake            payload
//   input     in         in_valid / in_stall  element_value
//   output    out        out_valid/out_stall  out_value, out_row, out_col, is_last
//   config    in         cfg_we               cfg_index, cfg_wdata
// Loading stores each accepted element; the last one of the matrix starts the
// emission, which runs one result per cycle while the output is not stalled,
// paced by the single store read port. in_stall is high throughout.
// A stalled output holds the result register and pauses the walker.
// Reset clears the load count, the walker and the output valid, and sets
// 4 rows by 4 columns; the element store is not cleared.
module spiral_order_matrix_reader
    import somr_pkg::*;
#(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 4
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  cfg_reg_t                   cfg_index,
    input  logic [CFG_W-1:0]           cfg_wdata,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [VALUE_W-1:0]  element_value,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [VALUE_W-1:0]  out_value,
    output logic [OUT_ROW_W-1:0]       out_row,
    output logic [OUT_COL_W-1:0]       out_col,
    output logic                       is_last
);

    somr_cmd_t cmd;
    somr_sts_t sts;

    somr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .in_stall  (in_stall),
        .cmd       (cmd)
    );

    somr_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .element_value (element_value),
        .cmd           (cmd),
        .sts           (sts),
        .out_value     (out_value),
        .out_row       (out_row),
        .out_col       (out_col),
        .is_last       (is_last)
    );

    assign out_valid = sts.out_valid;

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the spiral-order matrix reader: table-driven and random matrices.
module tb_top;
    import somr_pkg::*;

    localparam int MAX_ROWS = 16;
    localparam int MAX_COLS = 4;
    localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int STORE_AW = $clog2(STORE_DEPTH);
    localparam int RANDOM_ITEMS = 270;
    localparam int QUIET_LIMIT = 4000;
    localparam int STEPS = 37;

    typedef struct packed {
        logic [VALUE_W-1:0]   value;
        logic [OUT_ROW_W-1:0] row;
        logic [OUT_COL_W-1:0] col;
        logic                 last;
    } cell_t;

    typedef enum logic [1:0] {
        STEP_ROWS,
        STEP_COLS,
        STEP_ELEM,
        STEP_ELEM_KNOWN
    } step_kind_t;

    typedef struct packed {
        step_kind_t         kind;
        logic [VALUE_W-1:0] data;
    } step_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    cfg_reg_t                  cfg_index = REG_ROWS;
    logic [CFG_W-1:0]          cfg_wdata = '0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic signed [VALUE_W-1:0] element_value = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic signed [VALUE_W-1:0] out_value;
    logic [OUT_ROW_W-1:0]      out_row;
    logic [OUT_COL_W-1:0]      out_col;
    logic                      is_last;

    logic [VALUE_W-1:0]    matrix_mem [STORE_DEPTH];
    logic [6:0]            load_cnt = '0;
    logic [ROWS_CFG_W-1:0] rows_reg = ROWS_RESET;
    logic [COLS_CFG_W-1:0] cols_reg = COLS_RESET;
    cell_t                 spiral_q [$];
    cell_t                 known_q [$];

    int errors = 0;
    int quiet_cycles = 0;
    int hold_left = 0;
    int items_sent = 0;
    int drive_pos = 0;
    bit calm = 1'b0;
    bit in_gaps_on = 1'b1;
    bit out_gaps_on = 1'b1;

    step_t script [STEPS] = '{
        '{STEP_ROWS, 32'd1},
        '{STEP_COLS, 32'd1},
        '{STEP_ELEM_KNOWN, 32'h7FFF_FFFF},
        '{STEP_ELEM_KNOWN, 32'h8000_0000},
        '{STEP_ELEM_KNOWN, 32'h0000_0000},
        '{STEP_ELEM_KNOWN, 32'hFFFF_FFFF},
        '{STEP_ROWS, 32'd0},
        '{STEP_COLS, 32'd8},
        '{STEP_ELEM_KNOWN, 32'h5A5A_5A5A},
        '{STEP_ELEM_KNOWN, 32'hA5A5_A5A5},
        '{STEP_ROWS, 32'd2},
        '{STEP_COLS, 32'd3},
        '{STEP_ELEM, 32'h0000_0011},
        '{STEP_ELEM, 32'h0000_0012},
        '{STEP_ELEM, 32'h8000_0013},
        '{STEP_ELEM, 32'h0000_0021},
        '{STEP_ELEM, 32'hFFFF_FF22},
        '{STEP_ELEM, 32'h7FFF_0023},
        '{STEP_ROWS, 32'd3},
        '{STEP_COLS, 32'd1},
        '{STEP_ELEM, 32'h0000_0100},
        '{STEP_ELEM, 32'h0000_0200},
        '{STEP_ELEM, 32'h0000_0300},
        '{STEP_ROWS, 32'd1},
        '{STEP_COLS, 32'd7},
        '{STEP_ELEM, 32'h1111_1111},
        '{STEP_ELEM, 32'h2222_2222},
        '{STEP_ELEM, 32'h3333_3333},
        '{STEP_ELEM, 32'h4444_4444},
        '{STEP_ROWS, 32'd3},
        '{STEP_COLS, 32'd2},
        '{STEP_ELEM, 32'hC000_0001},
        '{STEP_ELEM, 32'hC000_0002},
        '{STEP_ELEM, 32'hC000_0003},
        '{STEP_ELEM, 32'hC000_0004},
        '{STEP_ELEM, 32'hC000_0005},
        '{STEP_ELEM, 32'hC000_0006}
    };

    spiral_order_matrix_reader #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .element_value (element_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_value     (out_value),
        .out_row       (out_row),
        .out_col       (out_col),
        .is_last       (is_last)
    );

    always #6 clk = ~clk;

    function automatic int row_count();
        if (rows_reg == 0)
        begin
            return 1;
        end
        if (rows_reg > MAX_ROWS)
        begin
            return MAX_ROWS;
        end
        return int'(rows_reg);
    endfunction

    function automatic int col_count();
        if (cols_reg == 0)
        begin
            return 1;
        end
        if (cols_reg > MAX_COLS)
        begin
            return MAX_COLS;
        end
        return int'(cols_reg);
    endfunction

    function automatic cell_t cell_at(input int r, input int c, input int nc, input bit last);
        cell_t res;
        res.value = matrix_mem[STORE_AW'((r * nc + c) % STORE_DEPTH)];
        res.row = r[OUT_ROW_W-1:0];
        res.col = c[OUT_COL_W-1:0];
        res.last = last;
        return res;
    endfunction

    task automatic load_element(input logic [VALUE_W-1:0] v);
        int nr;
        int nc;
        int total;
        int top;
        int bot;
        int lft;
        int rgt;
        int i;
        int n;
        cell_t batch [$];
        nr = row_count();
        nc = col_count();
        total = nr * nc;
        matrix_mem[load_cnt[5:0]] = v;
        load_cnt = load_cnt + 7'd1;
        if (int'(load_cnt) < total)
        begin
            return;
        end
        load_cnt = '0;
        top = 0;
        bot = nr - 1;
        lft = 0;
        rgt = nc - 1;
        n = 0;
        while (top <= bot && lft <= rgt)
        begin
            for (i = lft; i <= rgt; i++)
            begin
                batch = {batch, cell_at(top, i, nc, n == total - 1)};
                n++;
            end
            top++;
            for (i = top; i <= bot; i++)
            begin
                batch = {batch, cell_at(i, rgt, nc, n == total - 1)};
                n++;
            end
            rgt--;
            if (top <= bot)
            begin
                for (i = rgt; i >= lft; i--)
                begin
                    batch = {batch, cell_at(bot, i, nc, n == total - 1)};
                    n++;
                end
                bot--;
            end
            if (lft <= rgt)
            begin
                for (i = bot; i >= top; i--)
                begin
                    batch = {batch, cell_at(i, lft, nc, n == total - 1)};
                    n++;
                end
                lft++;
            end
        end
        if (known_q.size() != 0)
        begin
            spiral_q = {spiral_q, known_q.pop_front()};
        end
        else
        begin
            foreach (batch[j])
            begin
                spiral_q = {spiral_q, batch[j]};
            end
        end
    endtask

    task automatic apply_write(input cfg_reg_t idx, input logic [CFG_W-1:0] d);
        case (idx)
            REG_ROWS: rows_reg = d[ROWS_CFG_W-1:0];
            REG_COLS: cols_reg = d[COLS_CFG_W-1:0];
            default: ;
        endcase
    endtask

    task automatic check_cell();
        cell_t want;
        if (spiral_q.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected item, expected none, got value %h row %0d col %0d last %0d",
                     $time, out_value, out_row, out_col, is_last);
            return;
        end
        want = spiral_q.pop_front();
        if (out_value !== want.value)
        begin
            errors++;
            $display("%0t: out_value expected %h got %h", $time, want.value, out_value);
        end
        if (out_row !== want.row)
        begin
            errors++;
            $display("%0t: out_row expected %0d got %0d", $time, want.row, out_row);
        end
        if (out_col !== want.col)
        begin
            errors++;
            $display("%0t: out_col expected %0d got %0d", $time, want.col, out_col);
        end
        if (is_last !== want.last)
        begin
            errors++;
            $display("%0t: is_last expected %0d got %0d", $time, want.last, is_last);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                check_cell();
            end
            if (in_valid && !in_stall)
            begin
                load_element(element_value);
            end
            if (cfg_we)
            begin
                apply_write(cfg_index, cfg_wdata);
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    always @(posedge clk)
    begin
        if (calm || !out_gaps_on)
        begin
            out_stall <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (!out_stall && $urandom_range(3) == 0)
        begin
            out_stall <= 1'b1;
            hold_left <= $urandom_range(7, 0);
        end
        else
        begin
            out_stall <= 1'b0;
            hold_left <= $urandom_range(6, 0);
        end
    end

    task automatic send_element(input logic [VALUE_W-1:0] v);
        int gap;
        if (!calm && in_gaps_on && $urandom_range(3) == 0)
        begin
            gap = $urandom_range(8, 1);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        element_value <= v;
        do @(posedge clk); while (in_stall);
        items_sent++;
        drive_pos++;
        if (drive_pos >= row_count() * col_count())
        begin
            drive_pos = 0;
        end
    endtask

    task automatic send_matrix();
        do
        begin
            send_element($urandom);
        end
        while (drive_pos != 0);
    endtask

    // drain pending results, then wait for the walker to return to load
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (spiral_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] d);
        settle();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= d;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [CFG_W-1:0] pick_rows();
        int p;
        p = $urandom_range(99);
        if (p < 65)
        begin
            return CFG_W'($urandom_range(4, 1));
        end
        if (p < 75)
        begin
            return CFG_W'($urandom_range(15, 5));
        end
        if (p < 85)
        begin
            return '0;
        end
        return CFG_W'($urandom_range(31, 16));
    endfunction

    initial
    begin
        int start;
        int total;
        int k;
        cell_t fixed_res;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default 4 x 4 matrix straight out of reset
        send_matrix();

        foreach (script[s])
        begin
            case (script[s].kind)
                STEP_ROWS: write_reg(REG_ROWS, script[s].data[CFG_W-1:0]);
                STEP_COLS: write_reg(REG_COLS, script[s].data[CFG_W-1:0]);
                STEP_ELEM_KNOWN:
                begin
                    fixed_res = '{value: script[s].data, row: '0, col: '0, last: 1'b1};
                    known_q = {known_q, fixed_res};
                    send_element(script[s].data);
                end
                default: send_element(script[s].data);
            endcase
        end

        // largest size: fills every store entry
        write_reg(REG_ROWS, 5'd31);
        write_reg(REG_COLS, 5'd7);
        send_matrix();

        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            calm = (items_sent - start) > (RANDOM_ITEMS * 85 / 100);
            in_gaps_on = $urandom_range(3) != 0;
            out_gaps_on = $urandom_range(3) != 0;
            write_reg(REG_ROWS, pick_rows());
            write_reg(REG_COLS, CFG_W'($urandom_range(31)));
            repeat ($urandom_range(3, 1)) send_matrix();
            total = row_count() * col_count();
            if ($urandom_range(4) == 0 && total > 1)
            begin
                // resize in the middle of a load
                k = $urandom_range(total - 1, 1);
                repeat (k) send_element($urandom);
                if ($urandom_range(1) == 0)
                begin
                    write_reg(REG_ROWS, pick_rows());
                end
                else
                begin
                    write_reg(REG_COLS, CFG_W'($urandom_range(31)));
                end
                send_matrix();
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (spiral_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (errors == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
